// ===== hdl/dmoc_pkg.sv =====
// dmoc_pkg: shared types, constants and lookup tables for the millivolt string converter
// no dependencies; imported by every module of the block

package dmoc_pkg;

   // default number of kept fraction digits and the largest supported value
   localparam int FRAC_DIGITS_DEFAULT = 4;
   localparam int MAX_FRAC_DIGITS = 6;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // integer part and its limit
   localparam int INT_W = 31;
   localparam int INT_X_W = INT_W + 4;
   localparam logic [INT_X_W-1:0] INT_LIMIT = 35'd2147483647;

   // result word layout
   localparam int WORD_W = 32;
   localparam int OFFSET_SHIFT = 21;
   localparam int OFFSET_W = WORD_W - OFFSET_SHIFT;

   // scaling by 1024 and the width of the quotient
   localparam int MUL_SHIFT = 10;
   localparam int QUOT_BITS = 32;
   localparam int STEP_W = $clog2(QUOT_BITS);

   // table widths, sized for the largest fraction digit count
   localparam int TAB_CNT_W = 3;
   localparam int SCALE_TAB_W = 20;
   localparam int DENOM_TAB_W = 30;
   localparam int HALF_TAB_W = 29;

   // characters of interest
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // result status, also used as the running error code
   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BAD_CHAR,
      STATUS_OVERFLOW,
      STATUS_POSITIVE
   } status_type;

   // back end sequencer
   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_MUL,
      BACK_LOAD,
      BACK_DIV,
      BACK_DONE
   } back_state_type;

   // 10^n
   function automatic logic [SCALE_TAB_W-1:0] scale_of(input logic [TAB_CNT_W-1:0] n);
      logic [SCALE_TAB_W-1:0] s;
      case (n)
         3'd0: s = 20'd1;
         3'd1: s = 20'd10;
         3'd2: s = 20'd100;
         3'd3: s = 20'd1000;
         3'd4: s = 20'd10000;
         3'd5: s = 20'd100000;
         3'd6: s = 20'd1000000;
         default: s = 20'd1;
      endcase
      return s;
   endfunction

   // 10^n * 1000
   function automatic logic [DENOM_TAB_W-1:0] denom_of(input logic [TAB_CNT_W-1:0] n);
      logic [DENOM_TAB_W-1:0] s;
      case (n)
         3'd0: s = 30'd1000;
         3'd1: s = 30'd10000;
         3'd2: s = 30'd100000;
         3'd3: s = 30'd1000000;
         3'd4: s = 30'd10000000;
         3'd5: s = 30'd100000000;
         3'd6: s = 30'd1000000000;
         default: s = 30'd1000;
      endcase
      return s;
   endfunction

   // 10^n * 500, the rounding bias
   function automatic logic [HALF_TAB_W-1:0] half_of(input logic [TAB_CNT_W-1:0] n);
      logic [HALF_TAB_W-1:0] s;
      case (n)
         3'd0: s = 29'd500;
         3'd1: s = 29'd5000;
         3'd2: s = 29'd50000;
         3'd3: s = 29'd500000;
         3'd4: s = 29'd5000000;
         3'd5: s = 29'd50000000;
         3'd6: s = 29'd500000000;
         default: s = 29'd500;
      endcase
      return s;
   endfunction

endpackage

// ===== hdl/dmoc_front.sv =====
// dmoc_front: character parser; keeps sign, integer and fraction digits and the first error
// depends on dmoc_pkg; emits one record per string on the word marked last

module dmoc_front #(
   parameter int FRAC_DIGITS = dmoc_pkg::FRAC_DIGITS_DEFAULT,
   localparam int FRAC_W = $clog2(10 ** FRAC_DIGITS),
   localparam int CNT_W = $clog2(FRAC_DIGITS + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic                       in_ready,
   input  logic [7:0]                 in_char,
   input  logic                       in_last,
   output logic                       push_valid,
   output dmoc_pkg::status_type       rec_status,
   output logic                       rec_negative,
   output logic [dmoc_pkg::INT_W-1:0] rec_integer,
   output logic [FRAC_W-1:0]          rec_fraction,
   output logic [CNT_W-1:0]           rec_count
);
   import dmoc_pkg::*;

   localparam int FX_W = FRAC_W + 4;

   logic                neg_ff, neg_in;
   logic                frac_mode_ff, frac_mode_in;
   logic                first_ff, first_in;
   logic                ended_ff, ended_in;
   logic [INT_W-1:0]    int_ff, int_in;
   logic [FRAC_W-1:0]   frac_ff, frac_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   status_type          err_ff, err_in;

   logic                is_digit;
   logic [3:0]          digit;
   logic [INT_X_W-1:0]  int_x10;
   logic [FX_W-1:0]     frac_x10;
   logic                accept;

   assign accept = in_valid & in_ready;
   assign is_digit = in_char inside {[CHAR_ZERO:CHAR_NINE]};
   assign digit = in_char[3:0];
   assign int_x10 = INT_X_W'(int_ff) * INT_X_W'(10) + INT_X_W'(digit);
   assign frac_x10 = FX_W'(frac_ff) * FX_W'(10) + FX_W'(digit);

   // parse one character
   always_comb begin
      neg_in = neg_ff;
      frac_mode_in = frac_mode_ff;
      first_in = first_ff;
      ended_in = ended_ff;
      int_in = int_ff;
      frac_in = frac_ff;
      cnt_in = cnt_ff;
      err_in = err_ff;
      if (!ended_ff && err_ff == STATUS_OK) begin
         if (in_char == CHAR_NUL) begin
            ended_in = 1'b1;
         end else if (first_ff && in_char == CHAR_MINUS) begin
            neg_in = 1'b1;
            first_in = 1'b0;
         end else begin
            first_in = 1'b0;
            if (!frac_mode_ff) begin
               if (in_char == CHAR_POINT) begin
                  frac_mode_in = 1'b1;
               end else if (!is_digit) begin
                  err_in = STATUS_BAD_CHAR;
               end else if (int_x10 > INT_LIMIT) begin
                  err_in = STATUS_OVERFLOW;
               end else begin
                  int_in = int_x10[INT_W-1:0];
               end
            end else begin
               if (!is_digit) begin
                  err_in = STATUS_BAD_CHAR;
               end else if (cnt_ff < CNT_W'(FRAC_DIGITS)) begin
                  frac_in = frac_x10[FRAC_W-1:0];
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
      end
   end

   // record for the back end, taken from the updated state
   always_comb begin
      push_valid = accept & in_last;
      rec_negative = neg_in;
      rec_integer = int_in;
      rec_fraction = frac_in;
      rec_count = cnt_in;
      if (err_in != STATUS_OK) begin
         rec_status = err_in;
      end else if (!neg_in && (int_in != '0 || frac_in != '0)) begin
         rec_status = STATUS_POSITIVE;
      end else begin
         rec_status = STATUS_OK;
      end
   end

   // parser state, cleared on reset and after the last word of each string
   always_ff @(posedge clock) begin
      if (reset || (accept && in_last)) begin
         neg_ff <= 1'b0;
         frac_mode_ff <= 1'b0;
         first_ff <= 1'b1;
         ended_ff <= 1'b0;
         int_ff <= '0;
         frac_ff <= '0;
         cnt_ff <= '0;
         err_ff <= STATUS_OK;
      end else if (accept) begin
         neg_ff <= neg_in;
         frac_mode_ff <= frac_mode_in;
         first_ff <= first_in;
         ended_ff <= ended_in;
         int_ff <= int_in;
         frac_ff <= frac_in;
         cnt_ff <= cnt_in;
         err_ff <= err_in;
      end
   end

endmodule

// ===== hdl/dmoc_queue.sv =====
// dmoc_queue: small first-in first-out buffer of parsed records
// depends on dmoc_pkg for the default depth

module dmoc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = dmoc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import dmoc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] fill_ff;
   logic             do_push, do_pop;

   assign push_ready = fill_ff != CNT_W'(DEPTH);
   assign pop_valid = fill_ff != '0;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push = push_valid & push_ready;
   assign do_pop = pop_valid & pop_ready;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - CNT_W'(1);
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/dmoc_back.sv =====
// dmoc_back: converts one parsed record into status and offset word
// depends on dmoc_pkg; multiply by 10^n, then a bit-serial divide by 10^n * 1000

module dmoc_back #(
   parameter int FRAC_DIGITS = dmoc_pkg::FRAC_DIGITS_DEFAULT,
   localparam int FRAC_W = $clog2(10 ** FRAC_DIGITS),
   localparam int CNT_W = $clog2(FRAC_DIGITS + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rec_valid,
   output logic                        rec_ready,
   input  dmoc_pkg::status_type        rec_status,
   input  logic                        rec_negative,
   input  logic [dmoc_pkg::INT_W-1:0]  rec_integer,
   input  logic [FRAC_W-1:0]           rec_fraction,
   input  logic [CNT_W-1:0]            rec_count,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [dmoc_pkg::WORD_W-1:0] rsp_offset_word
);
   import dmoc_pkg::*;

   // value, dividend and divisor widths
   localparam int VW = INT_W + FRAC_W;
   localparam int NW = VW + MUL_SHIFT + 1;
   localparam int DW = FRAC_W + MUL_SHIFT;

   back_state_type      state_ff, state_in;
   status_type          stat_ff;
   logic                neg_ff;
   logic [INT_W-1:0]    int_ff;
   logic [FRAC_W-1:0]   frac_ff;
   logic [FRAC_W-1:0]   scale_ff;
   logic [DW-1:0]       denom_ff;
   logic [DW-1:0]       half_ff;
   logic [VW-1:0]       prod_ff;
   logic [DW-1:0]       rem_ff, rem_in;
   logic [QUOT_BITS-1:0] nq_ff, nq_in;
   logic [STEP_W-1:0]   step_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [WORD_W-1:0]   rsp_word_ff;

   logic [TAB_CNT_W-1:0] tab_cnt;
   logic [VW-1:0]        value;
   logic [NW-1:0]        dividend;
   logic [DW:0]          rem_shift;
   logic                 quot_bit;
   logic [OFFSET_W-1:0]  q_low;
   logic [OFFSET_W-1:0]  q_signed;
   logic [WORD_W-1:0]    word;
   logic                 take_rec;
   logic                 rsp_load;
   logic                 step_last;

   assign tab_cnt = TAB_CNT_W'(rec_count);
   assign value = prod_ff + VW'(frac_ff);
   assign dividend = NW'({value, MUL_SHIFT'(0)}) + NW'(half_ff);
   assign step_last = step_ff == STEP_W'(QUOT_BITS - 1);

   // one restoring divide step per cycle, dividend bits shift out of nq
   assign rem_shift = {rem_ff, nq_ff[QUOT_BITS-1]};
   assign quot_bit = rem_shift >= {1'b0, denom_ff};
   assign rem_in = quot_bit ? DW'(rem_shift - {1'b0, denom_ff}) : DW'(rem_shift);
   assign nq_in = {nq_ff[QUOT_BITS-2:0], quot_bit};

   // signed low quotient bits placed at the top of the word
   assign q_low = nq_ff[OFFSET_W-1:0];
   assign q_signed = neg_ff ? (~q_low + OFFSET_W'(1)) : q_low;
   assign word = (stat_ff == STATUS_OK) ? {q_signed, OFFSET_SHIFT'(0)} : '0;

   // sequencer outputs
   always_comb begin
      rec_ready = state_ff == BACK_IDLE;
      take_rec = (state_ff == BACK_IDLE) && rec_valid;
      rsp_load = (state_ff == BACK_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (rec_valid) begin
               state_in = (rec_status == STATUS_OK) ? BACK_MUL : BACK_DONE;
            end
         end
         BACK_MUL: state_in = BACK_LOAD;
         BACK_LOAD: state_in = BACK_DIV;
         BACK_DIV: begin
            if (step_last) begin
               state_in = BACK_DONE;
            end
         end
         BACK_DONE: begin
            if (rsp_load) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (take_rec) begin
         stat_ff <= rec_status;
         neg_ff <= rec_negative;
         int_ff <= rec_integer;
         frac_ff <= rec_fraction;
         scale_ff <= FRAC_W'(scale_of(tab_cnt));
         denom_ff <= DW'(denom_of(tab_cnt));
         half_ff <= DW'(half_of(tab_cnt));
      end
      if (state_ff == BACK_MUL) begin
         prod_ff <= VW'(int_ff) * VW'(scale_ff);
      end
      if (state_ff == BACK_LOAD) begin
         rem_ff <= dividend[NW-1:QUOT_BITS];
         nq_ff <= dividend[QUOT_BITS-1:0];
         step_ff <= '0;
      end
      if (state_ff == BACK_DIV) begin
         rem_ff <= rem_in;
         nq_ff <= nq_in;
         step_ff <= step_ff + STEP_W'(1);
      end
      if (rsp_load) begin
         rsp_status_ff <= stat_ff;
         rsp_word_ff <= word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_offset_word = rsp_word_ff;

endmodule

// ===== hdl/decimal_millivolt_to_offset_code_core.sv =====
// decimal_millivolt_to_offset_code_core: millivolt string to offset word, top level
// depends on dmoc_pkg, dmoc_front, dmoc_queue and dmoc_back
//
// Usage:
//   req_ channel: one character word per cycle when req_ready (req_char_code, req_last_char).
//   A string is an optional leading minus, integer digits, an optional point and
//   fraction digits; a zero character ends it early. req_last_char closes it.
//   rsp_ channel: one word per string (rsp_status, rsp_offset_word), given for the
//   word marked last. Status 0 ok, 1 bad character, 2 integer overflow, 3 positive.
// Throughput: the parser takes one character per cycle while req_ready is high. A
//   record queue, two entries deep by default, sits between parser and converter.
// Converter: for an ok string it takes the record from the queue, multiplies, loads
//   the divider, runs a one-bit-per-cycle divider over the quotient bits and loads
//   the result into the output register. A rejected string goes straight from the
//   take to the output register. The converter takes no new record until the
//   current result is loaded; when the queue is full, req_ready drops until the
//   converter frees an entry.
// Stall: the result sits in an output register until rsp_ready; the converter
//   finishes its record and waits; the parser keeps working until the queue fills.
// Reset: synchronous, active high; clears the parser, the queue, the converter sequencer and the output valid flag.

module decimal_millivolt_to_offset_code_core #(
   parameter int FRAC_DIGITS = dmoc_pkg::FRAC_DIGITS_DEFAULT,
   parameter int QUEUE_DEPTH = dmoc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_char_code,
   input  logic                        req_last_char,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [dmoc_pkg::WORD_W-1:0] rsp_offset_word
);
   import dmoc_pkg::*;

   localparam int FRAC_W = $clog2(10 ** FRAC_DIGITS);
   localparam int CNT_W = $clog2(FRAC_DIGITS + 1);
   localparam int REC_W = 2 + 1 + INT_W + FRAC_W + CNT_W;

   logic               push_valid, push_ready;
   status_type         f_status;
   logic               f_negative;
   logic [INT_W-1:0]   f_integer;
   logic [FRAC_W-1:0]  f_fraction;
   logic [CNT_W-1:0]   f_count;
   logic [REC_W-1:0]   push_data, pop_data;
   logic               pop_valid, pop_ready;
   status_type         b_status;
   logic               b_negative;
   logic [INT_W-1:0]   b_integer;
   logic [FRAC_W-1:0]  b_fraction;
   logic [CNT_W-1:0]   b_count;

   assign req_ready = push_ready;

   // parser
   dmoc_front #(
      .FRAC_DIGITS(FRAC_DIGITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid),
      .in_ready(req_ready),
      .in_char(req_char_code),
      .in_last(req_last_char),
      .push_valid(push_valid),
      .rec_status(f_status),
      .rec_negative(f_negative),
      .rec_integer(f_integer),
      .rec_fraction(f_fraction),
      .rec_count(f_count)
   );

   // record queue
   assign push_data = {f_status, f_negative, f_integer, f_fraction, f_count};

   dmoc_queue #(
      .WIDTH(REC_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data(push_data),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data(pop_data)
   );

   assign b_status = status_type'(pop_data[REC_W-1 -: 2]);
   assign b_negative = pop_data[REC_W-3];
   assign b_integer = pop_data[FRAC_W+CNT_W +: INT_W];
   assign b_fraction = pop_data[CNT_W +: FRAC_W];
   assign b_count = pop_data[CNT_W-1:0];

   // converter
   dmoc_back #(
      .FRAC_DIGITS(FRAC_DIGITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .rec_valid(pop_valid),
      .rec_ready(pop_ready),
      .rec_status(b_status),
      .rec_negative(b_negative),
      .rec_integer(b_integer),
      .rec_fraction(b_fraction),
      .rec_count(b_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_offset_word(rsp_offset_word)
   );

endmodule

// ===== test/tb.sv =====
// tb: self-checking bench for decimal_millivolt_to_offset_code_core
// depends on dmoc_pkg and the core; drives character strings, predicts and checks status words

module tb;
   import dmoc_pkg::*;

   localparam int KEPT_DIGITS = FRAC_DIGITS_DEFAULT;
   localparam int TARGET_CHARS = 1000;

   // one expected status word
   typedef struct {
      status_type       status;
      logic [WORD_W-1:0] word;
   } offset_result_type;

   // running parse of the current string plus the queue of predicted words
   class offset_word_scoreboard;
      bit                 is_negative;
      bit                 in_fraction;
      bit                 at_first_char;
      bit                 string_ended;
      logic [INT_W-1:0]   integer_part;
      logic [13:0]        fraction_part;
      logic [2:0]         fraction_count;
      status_type         error_code;
      offset_result_type  expected_words[$];
      int unsigned        errors;
      int unsigned        status_seen[4];

      function new();
         errors = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         clear_string();
      endfunction

      function void clear_string();
         is_negative = 1'b0;
         in_fraction = 1'b0;
         at_first_char = 1'b1;
         string_ended = 1'b0;
         integer_part = '0;
         fraction_part = '0;
         fraction_count = '0;
         error_code = STATUS_OK;
      endfunction

      // fold one character into the parse
      function void take_char(logic [7:0] c);
         logic        is_digit;
         logic [3:0]  digit;
         logic [63:0] wide;
         is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
         digit = is_digit ? c[3:0] : 4'd0;
         if (string_ended || error_code != STATUS_OK) return;
         if (c == CHAR_NUL) begin
            string_ended = 1'b1;
            return;
         end
         if (at_first_char && c == CHAR_MINUS) begin
            is_negative = 1'b1;
            at_first_char = 1'b0;
            return;
         end
         at_first_char = 1'b0;
         if (!in_fraction) begin
            if (c == CHAR_POINT) begin
               in_fraction = 1'b1;
            end else if (!is_digit) begin
               error_code = STATUS_BAD_CHAR;
            end else begin
               wide = 64'(integer_part) * 64'd10 + 64'(digit);
               if (wide > 64'(INT_LIMIT)) error_code = STATUS_OVERFLOW;
               else integer_part = wide[INT_W-1:0];
            end
         end else begin
            if (!is_digit) begin
               error_code = STATUS_BAD_CHAR;
            end else if (fraction_count < KEPT_DIGITS) begin
               fraction_part = fraction_part * 14'd10 + 14'(digit);
               fraction_count = fraction_count + 3'd1;
            end
         end
      endfunction

      // status and offset word for the finished string
      function offset_result_type conclude();
         offset_result_type r;
         logic [63:0]    scale;
         logic [63:0]    denom;
         logic [63:0]    value;
         logic [63:0]    quot;
         logic [31:0]    steps;
         r.word = '0;
         if (error_code != STATUS_OK) begin
            r.status = error_code;
         end else if (!is_negative && (integer_part != 0 || fraction_part != 0)) begin
            r.status = STATUS_POSITIVE;
         end else begin
            scale = 64'd1;
            repeat (fraction_count) scale = scale * 64'd10;
            denom = scale * 64'd1000;
            value = 64'(integer_part) * scale + 64'(fraction_part);
            // exact times 1024/1000, rounded half away from zero on the magnitude
            quot = (value * 64'd1024 + denom / 64'd2) / denom;
            steps = quot[31:0];
            if (is_negative) steps = 32'd0 - steps;
            r.word = steps << OFFSET_SHIFT;
            r.status = STATUS_OK;
         end
         return r;
      endfunction

      function void note_char(logic [7:0] c, logic last);
         take_char(c);
         if (last) begin
            expected_words.push_back(conclude());
            clear_string();
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(logic [1:0] status, logic [WORD_W-1:0] word);
         offset_result_type e;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected word status %0d offset %h", status, word));
            return;
         end
         e = expected_words.pop_front();
         status_seen[e.status]++;
         if (status !== e.status)
            report($sformatf("status %0d, expected %s", status, e.status.name()));
         if (word !== e.word)
            report($sformatf("offset word %h, expected %h", word, e.word));
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [7:0]        req_char_code;
   logic              req_last_char;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [1:0]        rsp_status;
   logic [WORD_W-1:0] rsp_offset_word;

   offset_word_scoreboard sb = new();
   logic [7:0]  string_chars[$];
   int unsigned counted_chars = 0;
   int unsigned strings_sent = 0;
   int          burst_left = 0;

   decimal_millivolt_to_offset_code_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .req_last_char   (req_last_char),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_offset_word (rsp_offset_word)
   );

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run limit
   initial begin
      #5000000;
      $display("end of test: mismatches");
      $finish;
   end

   // receiver stall pattern: free, random, sparse, or a solid stall
   initial begin : rsp_pattern
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = (mode == 3) ? $urandom_range(20, 40) : $urandom_range(20, 120);
         end
         mode_left--;
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ready <= 1'b0;
         endcase
      end
   end

   // result check
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_status, rsp_offset_word);
   end

   // string building
   task add_byte(logic [7:0] b, bit counted);
      string_chars.push_back(b);
      if (counted) counted_chars++;
   endtask

   task add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b1);
   endtask

   task add_number(bit negative);
      logic [63:0] ival;
      bit          no_int;
      int          n;
      if (negative) add_byte(CHAR_MINUS, 1'b1);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: ival = $urandom_range(0, 999);
         6, 7: ival = $urandom_range(0, 99999);
         8: ival = $urandom_range(0, 2147483647);
         default: ival = 0;
      endcase
      no_int = ($urandom_range(0, 11) == 0);
      if (!no_int) begin
         if ($urandom_range(0, 5) == 0) add_text("0");
         add_text($sformatf("%0d", ival));
      end
      if (no_int || $urandom_range(0, 1)) begin
         add_byte(CHAR_POINT, 1'b1);
         n = $urandom_range(0, 7);
         repeat (n) add_byte(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b1);
      end
   endtask

   // early terminator with ignored junk behind it
   task maybe_terminate();
      if ($urandom_range(0, 7) == 0) begin
         add_byte(CHAR_NUL, 1'b1);
         repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   task build_random_string();
      int          pick;
      int          pos;
      logic [63:0] big;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         add_number(1'b1);
         maybe_terminate();
      end else if (pick < 70) begin
         add_number(1'b0);
         maybe_terminate();
      end else if (pick < 78) begin
         // integers around the overflow limit
         case ($urandom_range(0, 5))
            0: big = 64'd2147483647;
            1: big = 64'd2147483648;
            2: big = 64'd2147483646;
            3: big = 64'd2147483647 + 64'($urandom_range(1, 100000));
            4: big = 64'd4294967295;
            default: big = 64'd99999999999;
         endcase
         if ($urandom_range(0, 1)) add_byte(CHAR_MINUS, 1'b1);
         add_text($sformatf("%0d", big));
         if ($urandom_range(0, 1)) add_text(".5");
      end else if (pick < 90) begin
         // well-formed string with one character spoiled
         add_number($urandom_range(0, 1));
         pos = $urandom_range(0, string_chars.size() - 1);
         case ($urandom_range(0, 2))
            0: string_chars[pos] = CHAR_MINUS;
            1: string_chars[pos] = CHAR_POINT;
            default: string_chars[pos] = 8'($urandom_range(0, 255));
         endcase
         maybe_terminate();
      end else begin
         repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   // send the built string, bursts of words with random gaps between them
   task send_string();
      int   gap;
      int   i;
      logic last;
      for (i = 0; i < string_chars.size(); i++) begin
         last = (i == string_chars.size() - 1);
         @(negedge clock);
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                    : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         req_valid <= 1'b1;
         req_char_code <= string_chars[i];
         req_last_char <= last;
         do @(posedge clock); while (!req_ready);
         sb.note_char(string_chars[i], last);
         burst_left--;
      end
      string_chars.delete();
      strings_sent++;
   endtask

   task send_text(string s);
      add_text(s);
      send_string();
   endtask

   // hold off until every predicted word has come back
   task drain_pause();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_char_code = '0;
      req_last_char = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: lone minus, positive, rounding, misplaced minus, second point,
      // empty string, early terminator, high byte, overflow
      send_text("-");
      send_text("5");
      send_text("-0.5");
      send_text("1-");
      send_text("-..");
      add_byte(CHAR_NUL, 1'b1);
      send_string();
      add_text("-9");
      add_byte(CHAR_NUL, 1'b1);
      add_byte("x", 1'b0);
      send_string();
      add_byte(8'hFF, 1'b1);
      send_string();
      send_text("-2147483648");
      drain_pause();

      // random strings
      while (counted_chars < TARGET_CHARS) begin
         build_random_string();
         send_string();
         if (strings_sent % 60 == 0) drain_pause();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("sent %0d strings, %0d counted characters", strings_sent, counted_chars);
      $display("words checked: %0d ok, %0d bad char, %0d overflow, %0d positive",
               sb.status_seen[STATUS_OK], sb.status_seen[STATUS_BAD_CHAR],
               sb.status_seen[STATUS_OVERFLOW], sb.status_seen[STATUS_POSITIVE]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
hdl/dmoc_pkg.sv
hdl/dmoc_front.sv
hdl/dmoc_queue.sv
hdl/dmoc_back.sv
hdl/decimal_millivolt_to_offset_code_core.sv
test/tb.sv
